>>> hdl/svcm_pkg.sv
`default_nettype none

package svcm_pkg;

    // Defaults for the top-level parameters
    localparam int COS_TABLE_DEPTH_DEF = 256;
    localparam int ANGLE_LIMIT_DEF     = 180;

    // Reset values
    localparam logic [7:0] RESET_ANGLE = 8'd180;
    localparam logic [7:0] RESET_SPEED = 8'd100;

    // Q30 fixed point
    localparam longint unsigned Q30_ONE  = 64'd1073741824;
    localparam longint unsigned Q30_HALF = 64'd536870912;
    localparam longint unsigned PI_Q30   = 64'd3373259426;

    // Request kinds
    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // Frame commands
    localparam logic [1:0] CMD_ABS = 2'd0;
    localparam logic [1:0] CMD_REL = 2'd1;
    localparam logic [7:0] CMD_MAX = 8'd3;

    // Frame status codes
    localparam logic [1:0] STAT_NONE    = 2'd0;
    localparam logic [1:0] STAT_OK      = 2'd1;
    localparam logic [1:0] STAT_SUM_ERR = 2'd2;
    localparam logic [1:0] STAT_REJECT  = 2'd3;

    // Parser phase: waiting for a command byte
    localparam logic [2:0] PHASE_CMD = 3'd0;

    // Motion flag bits
    localparam int FLG_START_ABS = 0;
    localparam int FLG_MOVING    = 1;
    localparam int FLG_START_REL = 2;
    localparam int FLG_CHECK_REL = 3;

    // Payload index of the checksum byte for each command
    function automatic logic [2:0] frame_last_idx(input logic [1:0] cmd);
        logic [2:0] res;
        case (cmd)
            CMD_ABS: res = 3'd2;
            CMD_REL: res = 3'd3;
            default: res = 3'd1;
        endcase
        return res;
    endfunction

    // sin^2 in Q30 from an angle t in Q30 radians (elaboration only)
    function automatic logic [30:0] sin2_q30(input longint unsigned t);
        longint unsigned t2;
        longint unsigned u;
        longint unsigned s;
        t2 = (t * t) >> 30;
        u  = Q30_ONE;
        u  = Q30_ONE - ((t2 * u) >> 30) / 110;
        u  = Q30_ONE - ((t2 * u) >> 30) / 72;
        u  = Q30_ONE - ((t2 * u) >> 30) / 42;
        u  = Q30_ONE - ((t2 * u) >> 30) / 20;
        u  = Q30_ONE - ((t2 * u) >> 30) / 6;
        s  = (t * u) >> 30;
        return 31'((s * s) >> 30);
    endfunction

endpackage

`default_nettype wire

>>> hdl/svcm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, 8-bit divisor.
module svcm_div #(
    parameter int NW = 16,
    parameter int CW = $clog2(NW + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [CW-1:0] steps,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [7:0]    divisor,
    output logic               busy,
    output logic               done,
    output logic [NW-1:0]      quotient,
    output logic [7:0]         remainder
);

    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [7:0]    r_reg;
    logic [7:0]    d_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [8:0] shifted;
    logic [9:0] trial;
    logic       ge;
    logic [7:0] r_next;

    assign shifted = {r_reg, q_reg[NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, d_reg};
    assign ge      = ~trial[9];
    assign r_next  = ge ? trial[7:0] : shifted[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[NW-2:0], ge};
            r_reg <= r_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

>>> hdl/servo_command_motion_controller_core.sv
`default_nettype none

// Channel | Direction | Handshake            | Payload
// s_      | in        | s_valid / s_ready    | s_mode, s_bus_byte
// m_      | out       | m_valid / m_ready    | m_servo_write, m_servo_angle,
//         |           |                      | m_servo_speed, m_frame_status
// cfg_    | in        | cfg_valid / cfg_ready| cfg_base_speed
//
// Bus bytes, transaction ends and linear ticks are registered as a pending
// result at acceptance and go through the push state into the output register.
// A tick with the raised-cosine profile (DW = clog2(COS_TABLE_DEPTH)) first has
// the shared bit-serial divider run 8 steps for the phase modulo and 8+DW steps
// for the table index. A zero span skips the divider.
// Synchronous active-low reset; no clearing pass is needed.
// s_ready is high only while the sequencer is idle; a finished result waits in
// the output register and a new request is still taken meanwhile. A second
// result waits in the push state while m_ready is low.
module servo_command_motion_controller_core
    import svcm_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF,
    parameter int ANGLE_LIMIT     = ANGLE_LIMIT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic [7:0] s_bus_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_servo_write,
    output logic [7:0]      m_servo_angle,
    output logic [7:0]      m_servo_speed,
    output logic [1:0]      m_frame_status,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_base_speed
);

    // Widths from the table depth
    localparam int DW   = $clog2(COS_TABLE_DEPTH);      // table index k
    localparam int KW   = $clog2(COS_TABLE_DEPTH + 1);  // holds D - k
    localparam int HALF = COS_TABLE_DEPTH / 2 + 1;      // folded table size
    localparam int MW   = $clog2(HALF);
    localparam int NW   = 8 + DW;                       // dm * D fits here
    localparam int CW   = $clog2(NW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_K_GO,
        ST_K_WAIT,
        ST_ROM,
        ST_MULT,
        ST_SAT,
        ST_PUSH
    } state_t;

    state_t state_reg;

    // Architectural state
    logic [7:0] base_speed_reg;
    logic [2:0] phase_reg;
    logic [1:0] cmd_reg;
    logic [7:0] payload_reg [3];
    logic [7:0] sum_reg;
    logic [7:0] target_reg;
    logic       profile_reg;
    logic       up_reg;
    logic [7:0] settled_reg;
    logic [7:0] step_reg;
    logic [3:0] flags_reg;

    // Next values, applied when a request is taken
    logic [2:0] phase_next;
    logic [1:0] cmd_next;
    logic [7:0] sum_next;
    logic [7:0] target_next;
    logic       profile_next;
    logic       up_next;
    logic [7:0] settled_next;
    logic [7:0] step_next;
    logic [3:0] flags_next;
    logic       pl_we;
    logic [1:0] pl_idx;

    // Result of the request, speed patched later for profiled ticks
    logic       res_write;
    logic [7:0] res_angle;
    logic [7:0] res_speed;
    logic [1:0] res_status;
    logic       need_prof;
    logic [7:0] span_c;
    logic [7:0] mag_c;
    logic       neg_c;

    // Pending result and profile datapath
    logic          p_write_reg;
    logic [7:0]    p_angle_reg;
    logic [7:0]    p_speed_reg;
    logic [1:0]    p_status_reg;
    logic [7:0]    span_reg;
    logic [7:0]    mag_reg;
    logic          neg_reg;
    logic [7:0]    dm_reg;
    logic [DW-1:0] k_reg;
    logic [30:0]   h_reg;
    logic [39:0]   prod_reg;

    // Output register
    logic       m_valid_reg;
    logic       m_write_reg;
    logic [7:0] m_angle_reg;
    logic [7:0] m_speed_reg;
    logic [1:0] m_status_reg;

    logic accept;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Shared divider: phase modulo first, then the table index.
    // ---------------------------------------------------------------------
    logic          div_start;
    logic [CW-1:0] div_steps;
    logic [NW-1:0] div_dividend;
    logic          div_busy;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [7:0]    div_rem;

    assign div_start = (state_reg == ST_MOD_GO) || (state_reg == ST_K_GO);
    // Modulo pass feeds the 8-bit magnitude in at the top, so 8 steps suffice.
    assign div_steps = (state_reg == ST_MOD_GO) ? CW'(8) : CW'(NW);
    assign div_dividend = (state_reg == ST_MOD_GO)
                        ? {mag_reg, {(NW-8){1'b0}}}
                        : NW'(dm_reg) * NW'(COS_TABLE_DEPTH);

    svcm_div #(
        .NW(NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .steps     (div_steps),
        .dividend  (div_dividend),
        .divisor   (span_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Non-negative modulo: a negative offset with a nonzero remainder wraps.
    logic [7:0] dm_c;
    assign dm_c = (neg_reg && (div_rem != 8'd0)) ? (span_reg - div_rem) : div_rem;

    // ---------------------------------------------------------------------
    // Raised-cosine table, folded at D/2: h(k) = sin^2(pi*k/D) in Q30.
    // ---------------------------------------------------------------------
    logic [30:0] h_rom [HALF];

    for (genvar gi = 0; gi < HALF; gi++) begin : g_rom
        localparam longint unsigned T_Q30 = 64'(gi) * PI_Q30 / 64'(COS_TABLE_DEPTH);
        assign h_rom[gi] = sin2_q30(T_Q30);
    end

    logic [KW-1:0] k_ext;
    logic [KW-1:0] k_mirror;
    logic [KW-1:0] m_full;
    logic [MW-1:0] m_idx;
    assign k_ext    = KW'(k_reg);
    assign k_mirror = KW'(COS_TABLE_DEPTH) - k_ext;
    assign m_full   = (k_ext <= k_mirror) ? k_ext : k_mirror;
    assign m_idx    = m_full[MW-1:0];

    // Speed = round(base * h / 2^30), clipped to 8 bits
    logic [9:0] v_c;
    assign v_c = prod_reg[39:30];

    // ---------------------------------------------------------------------
    // Request decode: frame parser and motion tick
    // ---------------------------------------------------------------------
    always_comb begin
        logic [3:0] fl;
        logic [7:0] stp;
        logic [2:0] idx;
        logic [8:0] rel_sum;
        logic [8:0] diff;
        logic [7:0] lo;
        logic [7:0] hi;

        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        sum_next     = sum_reg;
        target_next  = target_reg;
        profile_next = profile_reg;
        up_next      = up_reg;
        settled_next = settled_reg;
        step_next    = step_reg;
        flags_next   = flags_reg;
        pl_we        = 1'b0;
        res_write    = 1'b0;
        res_angle    = 8'd0;
        res_speed    = 8'd0;
        res_status   = STAT_NONE;
        need_prof    = 1'b0;

        fl     = flags_reg;
        stp    = step_reg;
        idx    = phase_reg - 3'd1;
        pl_idx = idx[1:0];

        if (target_reg > settled_reg) begin
            lo = settled_reg;
            hi = target_reg;
        end else begin
            lo = target_reg;
            hi = settled_reg;
        end
        span_c = hi - lo;

        unique case (s_mode)
            MODE_BYTE: begin
                if (phase_reg == PHASE_CMD) begin
                    if (s_bus_byte <= CMD_MAX) begin
                        cmd_next   = s_bus_byte[1:0];
                        sum_next   = 8'd0;
                        phase_next = 3'd1;
                    end
                end else if (idx < frame_last_idx(cmd_reg)) begin
                    pl_we      = 1'b1;
                    sum_next   = sum_reg + s_bus_byte;
                    phase_next = phase_reg + 3'd1;
                end else begin
                    phase_next = PHASE_CMD;
                    if (sum_reg != s_bus_byte) begin
                        res_status = STAT_SUM_ERR;
                    end else begin
                        res_status = STAT_OK;
                        case (cmd_reg)
                            CMD_ABS: begin
                                flags_next[FLG_START_ABS] = 1'b1;
                                target_next  = payload_reg[1];
                                profile_next = (payload_reg[0] != 8'd0);
                            end
                            CMD_REL: begin
                                flags_next[FLG_START_REL] = 1'b1;
                                up_next      = (payload_reg[1] != 8'd0);
                                target_next  = payload_reg[2];
                                profile_next = (payload_reg[0] != 8'd0);
                            end
                            default: ;  // storage commands: status only
                        endcase
                    end
                end
            end
            MODE_TICK: begin
                if (fl[FLG_START_ABS]) begin
                    stp = settled_reg;
                    fl[FLG_MOVING]    = 1'b1;
                    fl[FLG_START_ABS] = 1'b0;
                end else if (fl[FLG_START_REL] && !fl[FLG_MOVING]) begin
                    stp = settled_reg;
                    fl[FLG_CHECK_REL] = 1'b1;
                    fl[FLG_START_REL] = 1'b0;
                end
                step_next = stp;
                if (fl[FLG_MOVING]) begin
                    res_write = 1'b1;
                    if (stp != target_reg) begin
                        res_angle = stp;
                        res_speed = base_speed_reg;
                        need_prof = profile_reg;
                        step_next = (settled_reg > target_reg) ? stp - 8'd1 : stp + 8'd1;
                    end else begin
                        // arrival: final write at speed zero
                        res_angle      = target_reg;
                        settled_next   = target_reg;
                        fl[FLG_MOVING] = 1'b0;
                    end
                end
                if (fl[FLG_CHECK_REL]) begin
                    rel_sum = {1'b0, settled_next} + {1'b0, target_reg};
                    if (up_reg && (rel_sum <= 9'(ANGLE_LIMIT))) begin
                        target_next       = rel_sum[7:0];
                        fl[FLG_START_ABS] = 1'b1;
                    end else if (!up_reg && (settled_next >= target_reg)) begin
                        target_next       = settled_next - target_reg;
                        fl[FLG_START_ABS] = 1'b1;
                    end else begin
                        res_status = STAT_REJECT;
                    end
                    fl[FLG_CHECK_REL] = 1'b0;
                end
                flags_next = fl;
            end
            MODE_END: begin
                phase_next = PHASE_CMD;
                sum_next   = 8'd0;
            end
            default: ;
        endcase

        diff  = {1'b0, stp} - {1'b0, lo};
        neg_c = diff[8];
        mag_c = neg_c ? 8'(9'd0 - diff) : diff[7:0];
    end

    // ---------------------------------------------------------------------
    // Sequencer, architectural state and output register
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            base_speed_reg <= RESET_SPEED;
            phase_reg      <= PHASE_CMD;
            cmd_reg        <= 2'd0;
            sum_reg        <= 8'd0;
            target_reg     <= 8'd0;
            profile_reg    <= 1'b0;
            up_reg         <= 1'b0;
            settled_reg    <= RESET_ANGLE;
            step_reg       <= 8'd0;
            flags_reg      <= 4'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            // zero writes leave the speed alone
            if (cfg_valid && (cfg_base_speed != 8'd0)) begin
                base_speed_reg <= cfg_base_speed;
            end
            // the push state drives valid itself
            if (m_valid_reg && m_ready && (state_reg != ST_PUSH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        phase_reg   <= phase_next;
                        cmd_reg     <= cmd_next;
                        sum_reg     <= sum_next;
                        target_reg  <= target_next;
                        profile_reg <= profile_next;
                        up_reg      <= up_next;
                        settled_reg <= settled_next;
                        step_reg    <= step_next;
                        flags_reg   <= flags_next;
                        if (!need_prof) begin
                            state_reg <= ST_PUSH;
                        end else if (span_c == 8'd0) begin
                            state_reg <= ST_ROM;   // zero span: index 0
                        end else begin
                            state_reg <= ST_MOD_GO;
                        end
                    end
                end
                ST_MOD_GO:   state_reg <= ST_MOD_WAIT;
                ST_MOD_WAIT: if (div_done) state_reg <= ST_K_GO;
                ST_K_GO:     state_reg <= ST_K_WAIT;
                ST_K_WAIT:   if (div_done) state_reg <= ST_ROM;
                ST_ROM:      state_reg <= ST_MULT;
                ST_MULT:     state_reg <= ST_SAT;
                ST_SAT:      state_reg <= ST_PUSH;
                ST_PUSH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_write_reg  <= p_write_reg;
                        m_angle_reg  <= p_angle_reg;
                        m_speed_reg  <= p_speed_reg;
                        m_status_reg <= p_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (pl_we) begin
                payload_reg[pl_idx] <= s_bus_byte;
            end
            p_write_reg  <= res_write;
            p_angle_reg  <= res_angle;
            p_speed_reg  <= res_speed;
            p_status_reg <= res_status;
            span_reg     <= span_c;
            mag_reg      <= mag_c;
            neg_reg      <= neg_c;
            k_reg        <= '0;
        end
        if ((state_reg == ST_MOD_WAIT) && div_done) begin
            dm_reg <= dm_c;
        end
        if ((state_reg == ST_K_WAIT) && div_done) begin
            k_reg <= div_quo[DW-1:0];
        end
        if (state_reg == ST_ROM) begin
            h_reg <= h_rom[m_idx];
        end
        if (state_reg == ST_MULT) begin
            prod_reg <= 40'(base_speed_reg) * 40'(h_reg) + 40'(Q30_HALF);
        end
        if (state_reg == ST_SAT) begin
            p_speed_reg <= (v_c > 10'd255) ? 8'd255 : v_c[7:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_servo_write  = m_write_reg;
    assign m_servo_angle  = m_angle_reg;
    assign m_servo_speed  = m_speed_reg;
    assign m_frame_status = m_status_reg;

`ifndef NO_ASSERTIONS
    // New requests are only taken with the divider at rest
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy)
        else $error("request taken while divider busy");

    // Divider completions only land in the states that consume them
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_MOD_WAIT) || (state_reg == ST_K_WAIT))
        else $error("divider result dropped");

    // No servo write means angle and speed read zero
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_servo_write) |-> (m_servo_angle == 8'd0) && (m_servo_speed == 8'd0))
        else $error("servo fields set without a write");

    // A rejected relative move starts from rest, so no write goes with it
    a_reject_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_frame_status == STAT_REJECT)) |-> !m_servo_write)
        else $error("reject reported alongside a servo write");
`endif

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench
    import svcm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Mode code 3 has no name in the package; the block ignores it.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Storage commands: one payload byte and a checksum, checked but move nothing.
    localparam logic [7:0] CMD_STORE_ID    = 8'd2;
    localparam logic [7:0] CMD_STORE_SPEED = 8'd3;

    // Divisors of the sine series used for the raised-cosine factor.
    localparam int unsigned SIN_SERIES [5] = '{110, 72, 42, 20, 6};

    // One result as it leaves the m_ channel.
    typedef struct packed {
        logic       write;
        logic [7:0] angle;
        logic [7:0] speed;
        logic [1:0] status;
    } servo_out_t;

    localparam servo_out_t QUIET = '0;

    // Directed request: when typed is set, the fixed result is the expectation;
    // otherwise the predictor supplies it.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       typed;
        servo_out_t fixed;
    } directed_req_t;

    localparam int PLAN_LEN = 28;

    localparam directed_req_t PLAN [PLAN_LEN] = '{
        // tick straight out of reset: nothing moves
        '{MODE_TICK,  8'h00, 1'b1, QUIET},
        // command byte above 3 is dropped
        '{MODE_BYTE,  8'hFF, 1'b1, QUIET},
        // spare mode code does nothing
        '{MODE_SPARE, 8'hAA, 1'b1, QUIET},
        // absolute move, linear speed, 180 -> 179
        '{MODE_BYTE,  8'(CMD_ABS), 1'b1, QUIET},
        '{MODE_BYTE,  8'h00,   1'b1, QUIET},
        '{MODE_BYTE,  8'd179,  1'b1, QUIET},
        '{MODE_BYTE,  8'd179,  1'b1, '{1'b0, 8'd0, 8'd0, STAT_OK}},
        '{MODE_TICK,  8'h00,   1'b1, '{1'b1, 8'd180, 8'd100, STAT_NONE}},
        '{MODE_TICK,  8'hFF,   1'b1, '{1'b1, 8'd179, 8'd0, STAT_NONE}},
        // storage frame with a bad checksum
        '{MODE_BYTE,  CMD_STORE_ID, 1'b1, QUIET},
        '{MODE_BYTE,  8'h80,        1'b1, QUIET},
        '{MODE_BYTE,  8'h7F,        1'b1, '{1'b0, 8'd0, 8'd0, STAT_SUM_ERR}},
        // relative move up by one with the profile on; 179 + 1 stays in range
        '{MODE_BYTE,  8'(CMD_REL), 1'b1, QUIET},
        '{MODE_BYTE,  8'hFF,   1'b1, QUIET},
        '{MODE_BYTE,  8'h01,   1'b1, QUIET},
        '{MODE_BYTE,  8'h01,   1'b1, QUIET},
        '{MODE_BYTE,  8'h01,   1'b1, '{1'b0, 8'd0, 8'd0, STAT_OK}},
        '{MODE_TICK,  8'h00,   1'b1, QUIET},
        '{MODE_TICK,  8'h00,   1'b0, QUIET},
        '{MODE_TICK,  8'h00,   1'b1, '{1'b1, 8'd180, 8'd0, STAT_NONE}},
        // relative move down by 200 from 180 falls below zero
        '{MODE_BYTE,  8'(CMD_REL), 1'b1, QUIET},
        '{MODE_BYTE,  8'h00,   1'b1, QUIET},
        '{MODE_BYTE,  8'h00,   1'b1, QUIET},
        '{MODE_BYTE,  8'd200,  1'b1, QUIET},
        '{MODE_BYTE,  8'd200,  1'b1, '{1'b0, 8'd0, 8'd0, STAT_OK}},
        '{MODE_TICK,  8'h00,   1'b1, '{1'b0, 8'd0, 8'd0, STAT_REJECT}},
        // frame cut short by the end of the bus transaction
        '{MODE_BYTE,  8'(CMD_ABS), 1'b1, QUIET},
        '{MODE_END,   8'h55,   1'b1, QUIET}
    };

    // Base speeds applied between random phases; index 5 is drawn at random.
    localparam int PHASES = 7;
    localparam int PHASE_REQS = 250;
    localparam logic [7:0] SPEED_STEPS [PHASES] = '{
        8'd255, 8'd1, 8'd0, 8'd128, 8'd127, 8'd0, 8'd255
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode = MODE_BYTE;
    logic [7:0] s_bus_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_servo_write;
    logic [7:0] m_servo_angle;
    logic [7:0] m_servo_speed;
    logic [1:0] m_frame_status;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_base_speed = 8'h00;

    servo_command_motion_controller_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_bus_byte     (s_bus_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_servo_write  (m_servo_write),
        .m_servo_angle  (m_servo_angle),
        .m_servo_speed  (m_servo_speed),
        .m_frame_status (m_frame_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_base_speed (cfg_base_speed)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor state: parser, move target and the running motion.
    // ---------------------------------------------------------------------
    logic [7:0] speed_reg  = RESET_SPEED;
    logic [2:0] rx_phase   = PHASE_CMD;
    logic [1:0] rx_cmd     = CMD_ABS;
    logic [7:0] rx_payload [3];
    logic [7:0] rx_sum     = 8'd0;
    logic [7:0] goal_angle = 8'd0;
    logic       shaped     = 1'b0;
    logic       heading_up = 1'b0;
    logic [7:0] rest_angle = RESET_ANGLE;
    logic [7:0] cur_angle  = 8'd0;
    logic [3:0] motion     = 4'd0;

    servo_out_t servo_expect_q [$];
    int         errors      = 0;
    int         useful_reqs = 0;
    int         tx_quiet    = 0;
    int         rx_quiet    = 0;

    // sin^2(pi*k/D) in Q30: the raised-cosine factor for table slot k.
    function automatic longint unsigned sin_sq_q30(input int unsigned idx);
        longint unsigned t, t2, u, s;
        int unsigned k, m;
        k = idx % COS_TABLE_DEPTH_DEF;
        m = (k <= COS_TABLE_DEPTH_DEF - k) ? k : COS_TABLE_DEPTH_DEF - k;
        t = 64'(m) * PI_Q30 / 64'(COS_TABLE_DEPTH_DEF);
        t2 = (t * t) >> 30;
        u = Q30_ONE;
        for (int i = 0; i < 5; i++)
            u = Q30_ONE - ((t2 * u) >> 30) / 64'(SIN_SERIES[i]);
        s = (t * u) >> 30;
        return (s * s) >> 30;
    endfunction

    // Shaped speed for the current step: phase is the step's place across the
    // span between rest and goal, taken with a non-negative modulo.
    function automatic logic [7:0] shaped_speed();
        int lo, hi, span, dm;
        int unsigned k;
        longint unsigned v;
        if (goal_angle > rest_angle) begin
            lo = int'(rest_angle);
            hi = int'(goal_angle);
        end else begin
            lo = int'(goal_angle);
            hi = int'(rest_angle);
        end
        span = hi - lo;
        k = 0;
        if (span > 0) begin
            dm = (((int'(cur_angle) - lo) % span) + span) % span;
            k = int'(dm * COS_TABLE_DEPTH_DEF / span);
        end
        v = (64'(speed_reg) * sin_sq_q30(k) + Q30_HALF) >> 30;
        return (v > 64'd255) ? 8'hFF : v[7:0];
    endfunction

    // Applies one request to the predictor state and returns the servo result.
    function automatic servo_out_t predict_servo(input logic [1:0] mode,
                                                 input logic [7:0] data);
        servo_out_t r;
        int flen, rest_i, amt_i;
        r = '0;
        case (mode)
            MODE_BYTE: begin
                // payload length counts the checksum byte
                flen = (rx_cmd == CMD_ABS) ? 3 : (rx_cmd == CMD_REL) ? 4 : 2;
                if (rx_phase == PHASE_CMD) begin
                    if (data <= CMD_MAX) begin
                        rx_cmd = data[1:0];
                        rx_sum = 8'd0;
                        rx_phase = 3'd1;
                    end
                end else if (rx_phase < flen) begin
                    rx_payload[2'(rx_phase - 3'd1)] = data;
                    rx_sum = rx_sum + data;
                    rx_phase = rx_phase + 3'd1;
                end else begin
                    rx_phase = PHASE_CMD;
                    if (rx_sum != data) begin
                        r.status = STAT_SUM_ERR;
                    end else begin
                        r.status = STAT_OK;
                        if (rx_cmd == CMD_ABS) begin
                            motion[FLG_START_ABS] = 1'b1;
                            goal_angle = rx_payload[1];
                            shaped = rx_payload[0] != 8'd0;
                        end else if (rx_cmd == CMD_REL) begin
                            motion[FLG_START_REL] = 1'b1;
                            heading_up = rx_payload[1] != 8'd0;
                            goal_angle = rx_payload[2];
                            shaped = rx_payload[0] != 8'd0;
                        end
                    end
                end
            end
            MODE_END: begin
                rx_phase = PHASE_CMD;
                rx_sum = 8'd0;
            end
            MODE_TICK: begin
                // absolute start wins; relative start waits for the move to end
                if (motion[FLG_START_ABS]) begin
                    cur_angle = rest_angle;
                    motion[FLG_MOVING] = 1'b1;
                    motion[FLG_START_ABS] = 1'b0;
                end else if (motion[FLG_START_REL] && !motion[FLG_MOVING]) begin
                    cur_angle = rest_angle;
                    motion[FLG_CHECK_REL] = 1'b1;
                    motion[FLG_START_REL] = 1'b0;
                end
                if (motion[FLG_MOVING]) begin
                    r.write = 1'b1;
                    if (cur_angle != goal_angle) begin
                        r.angle = cur_angle;
                        r.speed = shaped ? shaped_speed() : speed_reg;
                        // direction follows rest vs goal, so a moved goal wraps
                        if (rest_angle > goal_angle)
                            cur_angle = cur_angle - 8'd1;
                        else
                            cur_angle = cur_angle + 8'd1;
                    end else begin
                        r.angle = goal_angle;
                        r.speed = 8'd0;
                        rest_angle = goal_angle;
                        motion[FLG_MOVING] = 1'b0;
                    end
                end
                if (motion[FLG_CHECK_REL]) begin
                    rest_i = int'(rest_angle);
                    amt_i = int'(goal_angle);
                    if (heading_up && rest_i + amt_i <= ANGLE_LIMIT_DEF) begin
                        goal_angle = 8'(rest_i + amt_i);
                        motion[FLG_START_ABS] = 1'b1;
                    end else if (!heading_up && rest_i - amt_i >= 0) begin
                        goal_angle = 8'(rest_i - amt_i);
                        motion[FLG_START_ABS] = 1'b1;
                    end else begin
                        r.status = STAT_REJECT;
                    end
                    motion[FLG_CHECK_REL] = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Idle cycles before the next request or result; now and then a quiet
    // stretch with no idling at all.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            quiet_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Presents one request and holds it until taken, then records what the
    // result must be. Valid stays high on return; the caller either sends the
    // next request in the same step or drops valid.
    task automatic send_req(input logic [1:0] mode, input logic [7:0] data,
                            input logic typed = 1'b0,
                            input servo_out_t fixed = '0);
        int gap;
        servo_out_t exp_out;
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_bus_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // ignored requests do not count toward the random quota
        if (!(mode == MODE_SPARE ||
              (mode == MODE_BYTE && rx_phase == PHASE_CMD && data > CMD_MAX)))
            useful_reqs++;
        exp_out = predict_servo(mode, data);
        servo_expect_q.push_back(typed ? fixed : exp_out);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_req(MODE_TICK, 8'($urandom));
    endtask

    // Base speed goes in only with the block drained. Every request yields a
    // result, so an empty queue means the sequencer is idle.
    task automatic write_base_speed(input logic [7:0] v);
        s_valid <= 1'b0;
        while (servo_expect_q.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_base_speed <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        // zero is refused by the block
        if (v != 8'd0)
            speed_reg = v;
    endtask

    // Mostly well-formed frames with random content and tick bursts to run the
    // moves; the rest is broken frames, stray bytes and spare mode codes.
    task automatic random_phase(input int quota);
        int base_cnt, pick, n;
        logic [7:0] prof, tgt, dir, amt, val, sum, cmd;
        base_cnt = useful_reqs;
        while (useful_reqs - base_cnt < quota) begin
            pick = $urandom_range(0, 99);
            prof = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
            if (pick < 35) begin
                tgt = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, ANGLE_LIMIT_DEF));
                sum = prof + tgt;
                if ($urandom_range(0, 9) == 0)
                    sum = sum ^ 8'($urandom_range(1, 255));
                send_req(MODE_BYTE, 8'(CMD_ABS));
                send_req(MODE_BYTE, prof);
                send_req(MODE_BYTE, tgt);
                send_req(MODE_BYTE, sum);
            end else if (pick < 60) begin
                dir = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                amt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 45));
                sum = prof + dir + amt;
                if ($urandom_range(0, 9) == 0)
                    sum = sum ^ 8'($urandom_range(1, 255));
                send_req(MODE_BYTE, 8'(CMD_REL));
                send_req(MODE_BYTE, prof);
                send_req(MODE_BYTE, dir);
                send_req(MODE_BYTE, amt);
                send_req(MODE_BYTE, sum);
            end else if (pick < 68) begin
                cmd = ($urandom_range(0, 1) == 0) ? CMD_STORE_ID : CMD_STORE_SPEED;
                val = 8'($urandom);
                sum = ($urandom_range(0, 4) == 0) ? 8'($urandom) : val;
                send_req(MODE_BYTE, cmd);
                send_req(MODE_BYTE, val);
                send_req(MODE_BYTE, sum);
            end else if (pick < 78) begin
                case ($urandom_range(0, 4))
                    0: send_req(MODE_BYTE, 8'($urandom_range(CMD_MAX + 1, 255)));
                    1: send_req(MODE_SPARE, 8'($urandom));
                    2: begin
                        // frame dropped by the end of the transaction
                        send_req(MODE_BYTE, 8'($urandom_range(0, CMD_MAX)));
                        n = $urandom_range(0, 2);
                        repeat (n) send_req(MODE_BYTE, 8'($urandom));
                        send_req(MODE_END, 8'($urandom));
                    end
                    3: send_req(MODE_END, 8'($urandom));
                    default: send_req(MODE_BYTE, 8'($urandom));
                endcase
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 260)
                                                : $urandom_range(1, 12);
                send_ticks(n);
            end
            if (pick < 68 && $urandom_range(0, 2) != 0)
                send_ticks($urandom_range(1, 25));
        end
    endtask

    // Field-by-field compare against the oldest expectation.
    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side: random back-pressure, then check each accepted result.
    initial begin
        int gap;
        servo_out_t got, want;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_wait(rx_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = '{m_servo_write, m_servo_angle, m_servo_speed, m_frame_status};
            if (servo_expect_q.size() == 0) begin
                $display("%0t ns: servo result with no request waiting, expected none, got %h",
                         $time, got);
                errors++;
            end else begin
                want = servo_expect_q.pop_front();
                check_field("servo_write", int'(want.write), int'(got.write));
                check_field("servo_angle", int'(want.angle), int'(got.angle));
                check_field("servo_speed", int'(want.speed), int'(got.speed));
                check_field("frame_status", int'(want.status), int'(got.status));
            end
        end
    end

    // Request side: directed table, then random phases at several base speeds.
    initial begin
        logic [7:0] spd;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_base_speed(RESET_SPEED);
        for (int i = 0; i < PLAN_LEN; i++)
            send_req(PLAN[i].mode, PLAN[i].data, PLAN[i].typed, PLAN[i].fixed);
        for (int p = 0; p < PHASES; p++) begin
            spd = (p == 5) ? 8'($urandom_range(1, 255)) : SPEED_STEPS[p];
            write_base_speed(spd);
            random_phase(PHASE_REQS);
        end
        s_valid <= 1'b0;
        while (servo_expect_q.size() != 0) @(posedge aclk);
        // allow for a stray late result after a shaped tick
        repeat (64) @(posedge aclk);
        if (errors == 0)
            $display("servo_command_motion_controller_core verification clean");
        else
            $display("servo_command_motion_controller_core verification failed");
        $finish;
    end

    // Watchdog: a correct run needs well under a quarter of this.
    initial begin
        #2_000_000;
        $display("servo_command_motion_controller_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/svcm_pkg.sv
hdl/svcm_div.sv
hdl/servo_command_motion_controller_core.sv
tb/sv/testbench.sv
